[rtl/core/table_bisect_linear_interp_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the table lookup core
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TABLE_BISECT_LINEAR_INTERP_CORE_DEFINES_SVH
`define TABLE_BISECT_LINEAR_INTERP_CORE_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define TBLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define TBLI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/core/tbli_pkg.sv]
// ----------------------------------------------------------------------------
// Table lookup core package
// Sizes, codes and types shared by the table lookup core and its units.
// ----------------------------------------------------------------------------
`default_nettype none

package tbli_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int PTS_W       = 7;
  localparam int DATA_W      = 32;

  localparam logic [PTS_W-1:0] PTS_RESET = PTS_W'(2);

  localparam int DIVIDEND_W         = 2 * DATA_W;
  localparam int DIVISOR_W          = DATA_W;
  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam int DIV_STEPS          = DIVIDEND_W / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W          = $clog2(DIV_STEPS);

  localparam int SUM_W = DATA_W + 3;
  localparam logic [DATA_W+1:0] QUO_SAT = {2'b10, {DATA_W{1'b0}}};

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FEW_POINTS = 2'd1,
    ST_ZERO_WIDTH = 2'd2
  } status_t;

endpackage

`default_nettype wire

[rtl/core/tbli_ram.sv]
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tbli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/tbli_div.sv]
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division of a 64-bit dividend by a nonzero 32-bit divisor,
// retiring two quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tbli_div
  import tbli_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic      [DIVIDEND_W-1:0] quotient
);

  logic                  running;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIVISOR_W-1:0]  den;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] work;
  logic [DIVISOR_W-1:0]  rem_next;
  logic [DIVIDEND_W-1:0] work_next;

  always_comb begin
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W-1:0]  r;
    logic [DIVIDEND_W-1:0] w;
    logic                  ge;
    r = rem;
    w = work;
    for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
      trial = {r, w[DIVIDEND_W-1]};
      ge    = (trial >= {1'b0, den});
      if (ge) begin
        r = DIVISOR_W'(trial - {1'b0, den});
      end else begin
        r = trial[DIVISOR_W-1:0];
      end
      w = {w[DIVIDEND_W-2:0], ge};
    end
    rem_next  = r;
    work_next = w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= DIV_CNT_W'(DIV_STEPS - 1);
        den     <= divisor;
        rem     <= '0;
        work    <= dividend;
      end else if (running) begin
        rem  <= rem_next;
        work <= work_next;
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient = work;

endmodule

`default_nettype wire

[rtl/core/table_bisect_linear_interp_core.sv]
// ----------------------------------------------------------------------------
// Piecewise-linear table lookup core
// A write transaction stores one signed Q16.16 (x, y) breakpoint in a 64-entry
// table and returns a zero result. A query transaction bisects the first
// points_in_use entries, at most 64 (ascending or descending, taken from the
// first and last entries), then returns
// y0 + (y1 - y0) * (q - x0) / (x1 - x0), truncated toward zero and saturated to
// 32 bits; outside the table it extrapolates from the end segment. The table
// sits in one single-port-read RAM, so each bisection step costs one read. A
// full query waits on the serial divider that retires two quotient bits per
// cycle; a zero-width segment or a lookup with fewer than two points skips the
// divider. One transaction is processed at a time; a new one is taken while
// the previous result still waits at the output register. Entries read by a
// query must have been written first; the table has no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module table_bisect_linear_interp_core
  import tbli_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write_en,
  input  wire logic [PTS_W-1:0]   cfg_write_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               action,
  input  wire logic [5:0]         entry_index,
  input  wire logic signed [31:0] entry_x,
  input  wire logic signed [31:0] entry_y,
  input  wire logic signed [31:0] query_x,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      result_y,
  output logic [5:0]              segment,
  output logic [1:0]              status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAST,
    S_ORDER,
    S_BIS,
    S_SEG0,
    S_SEG1,
    S_MUL,
    S_DSTART,
    S_DIV,
    S_EMIT
  } state_t;

  state_t state;

  logic [PTS_W-1:0]         points_in_use;
  logic [PTS_W-1:0]         n_eff;
  logic [IDX_W-1:0]         n_m1;
  logic signed [DATA_W-1:0] q;
  logic signed [DATA_W-1:0] x_first;
  logic signed [DATA_W-1:0] x0;
  logic signed [DATA_W-1:0] y0;
  logic                     asc;
  logic [IDX_W-1:0]         lo;
  logic [IDX_W-1:0]         hi;
  logic [IDX_W-1:0]         mid;
  logic [DATA_W-1:0]        mag_dx;
  logic [DATA_W-1:0]        mag_dy;
  logic [DATA_W-1:0]        mag_dq;
  logic                     neg;
  logic [DIVIDEND_W-1:0]    prod;
  logic signed [DATA_W-1:0] res_y;
  logic [IDX_W-1:0]         res_seg;
  status_t                  res_status;

  logic                     in_fire;
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_raddr;
  logic [2*DATA_W-1:0]      ram_rdata;
  logic signed [DATA_W-1:0] rd_x;
  logic signed [DATA_W-1:0] rd_y;

  logic                     go_lo;
  logic [IDX_W-1:0]         lo_step;
  logic [IDX_W-1:0]         hi_step;
  logic [IDX_W-1:0]         span_step;
  logic [IDX_W-1:0]         mid_step;
  logic [IDX_W-1:0]         mid_first;

  logic signed [DATA_W:0]   dx;
  logic signed [DATA_W:0]   dy;
  logic signed [DATA_W:0]   dq;
  logic signed [DATA_W:0]   ndx;
  logic signed [DATA_W:0]   ndy;
  logic signed [DATA_W:0]   ndq;

  logic                     div_start;
  logic                     div_done;
  logic [DIVIDEND_W-1:0]    div_quo;
  logic [DATA_W+1:0]        quo_sat;
  logic signed [SUM_W-1:0]  sum;
  logic signed [DATA_W-1:0] sat_y;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign ram_we   = in_fire && (action == ACT_WRITE);

  assign n_eff = (points_in_use > PTS_W'(TABLE_DEPTH)) ? PTS_W'(TABLE_DEPTH) : points_in_use;

  assign rd_x = $signed(ram_rdata[2*DATA_W-1:DATA_W]);
  assign rd_y = $signed(ram_rdata[DATA_W-1:0]);

  tbli_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(entry_index)),
    .wdata ({entry_x, entry_y}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    go_lo     = ((q >= rd_x) == asc);
    lo_step   = go_lo ? mid : lo;
    hi_step   = go_lo ? hi : mid;
    span_step = hi_step - lo_step;
    mid_step  = IDX_W'(({1'b0, lo_step} + {1'b0, hi_step}) >> 1);
    mid_first = n_m1 >> 1;
  end

  always_comb begin
    case (state)
      S_LAST:  ram_raddr = n_m1;
      S_ORDER: ram_raddr = (n_m1 > IDX_W'(1)) ? mid_first : '0;
      S_BIS:   ram_raddr = (span_step > IDX_W'(1)) ? mid_step : lo_step;
      S_SEG0:  ram_raddr = lo + 1'b1;
      default: ram_raddr = '0;
    endcase
  end

  always_comb begin
    dx  = {rd_x[DATA_W-1], rd_x} - {x0[DATA_W-1], x0};
    dy  = {rd_y[DATA_W-1], rd_y} - {y0[DATA_W-1], y0};
    dq  = {q[DATA_W-1], q} - {x0[DATA_W-1], x0};
    ndx = -dx;
    ndy = -dy;
    ndq = -dq;
  end

  assign div_start = (state == S_DSTART);

  tbli_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (mag_dx),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    if (div_quo > DIVIDEND_W'(QUO_SAT)) begin
      quo_sat = QUO_SAT;
    end else begin
      quo_sat = div_quo[DATA_W+1:0];
    end
    if (neg) begin
      sum = SUM_W'(y0) - $signed({1'b0, quo_sat});
    end else begin
      sum = SUM_W'(y0) + $signed({1'b0, quo_sat});
    end
    if (!sum[SUM_W-1] && (sum[SUM_W-2:DATA_W-1] != '0)) begin
      sat_y = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (sum[SUM_W-1] && (sum[SUM_W-2:DATA_W-1] != '1)) begin
      sat_y = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_y = sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      points_in_use <= PTS_RESET;
    end else begin
      if (cfg_write_en) begin
        points_in_use <= cfg_write_data;
      end
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            q    <= query_x;
            n_m1 <= IDX_W'(n_eff - 1'b1);
            if (action == ACT_WRITE) begin
              res_y      <= '0;
              res_seg    <= '0;
              res_status <= ST_OK;
              state      <= S_EMIT;
            end else if (n_eff < PTS_W'(2)) begin
              res_y      <= '0;
              res_seg    <= '0;
              res_status <= ST_FEW_POINTS;
              state      <= S_EMIT;
            end else begin
              state <= S_LAST;
            end
          end
        end
        S_LAST: begin
          x_first <= rd_x;
          state   <= S_ORDER;
        end
        S_ORDER: begin
          asc <= (rd_x >= x_first);
          lo  <= '0;
          hi  <= n_m1;
          mid <= mid_first;
          if (n_m1 > IDX_W'(1)) begin
            state <= S_BIS;
          end else begin
            state <= S_SEG0;
          end
        end
        S_BIS: begin
          lo  <= lo_step;
          hi  <= hi_step;
          mid <= mid_step;
          if (span_step <= IDX_W'(1)) begin
            state <= S_SEG0;
          end
        end
        S_SEG0: begin
          x0    <= rd_x;
          y0    <= rd_y;
          state <= S_SEG1;
        end
        S_SEG1: begin
          if (dx == '0) begin
            res_y      <= y0;
            res_seg    <= lo;
            res_status <= ST_ZERO_WIDTH;
            state      <= S_EMIT;
          end else begin
            mag_dx <= dx[DATA_W] ? ndx[DATA_W-1:0] : dx[DATA_W-1:0];
            mag_dy <= dy[DATA_W] ? ndy[DATA_W-1:0] : dy[DATA_W-1:0];
            mag_dq <= dq[DATA_W] ? ndq[DATA_W-1:0] : dq[DATA_W-1:0];
            neg    <= dy[DATA_W] ^ dq[DATA_W] ^ dx[DATA_W];
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= DIVIDEND_W'(mag_dy) * DIVIDEND_W'(mag_dq);
          state <= S_DSTART;
        end
        S_DSTART: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_y      <= sat_y;
            res_seg    <= lo;
            res_status <= ST_OK;
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            result_y  <= res_y;
            segment   <= 6'(res_seg);
            status    <= res_status;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/tbli_checker.sv]
// ----------------------------------------------------------------------------
// Port checker for the table lookup core
// Watches the handshakes and result codes at the core's ports.
// ----------------------------------------------------------------------------
`default_nettype none
`include "table_bisect_linear_interp_core_defines.svh"

module tbli_checker
  import tbli_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               action,
  input wire logic [5:0]         entry_index,
  input wire logic signed [31:0] entry_x,
  input wire logic signed [31:0] entry_y,
  input wire logic signed [31:0] query_x,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] result_y,
  input wire logic [5:0]         segment,
  input wire logic [1:0]         status
);

  logic [102:0] in_payload;
  logic [39:0]  out_payload;

  assign in_payload  = {action, entry_index, entry_x, entry_y, query_x};
  assign out_payload = {result_y, segment, status};

  // A stalled input transaction keeps its payload.
  `TBLI_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_payload), "input transaction changed while stalled")

  // A stalled result keeps its payload.
  `TBLI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload), "result changed while stalled")

  // The core works on one transaction at a time.
  `TBLI_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input accepted while busy")

  // A lookup with fewer than two points carries a zero value and segment.
  `TBLI_ASSERT_SAME(a_few_points, out_valid && (status == ST_FEW_POINTS), (result_y == 0) && (segment == 0), "bad result for too few points")

endmodule

bind table_bisect_linear_interp_core tbli_checker u_tbli_checker (.*);

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the piecewise-linear table lookup core
// Fills the breakpoint table with ascending, descending, flat-step and
// scrambled tables over several table sizes. It then queries inside, on and
// outside the breakpoints, and checks every result against an in-order
// prediction of the table, the bisection, the divide and the saturation.
// ----------------------------------------------------------------------------

module testbench;
  import tbli_pkg::*;

  localparam int RUN_LIMIT    = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASES       = 12;

  localparam longint Y_MAX = 64'sd2147483647;
  localparam longint Y_MIN = -64'sd2147483648;

  typedef enum logic [1:0] {
    SHAPE_ASC,
    SHAPE_DESC,
    SHAPE_DUP,
    SHAPE_SCRAMBLE
  } table_shape_t;

  typedef struct {
    logic               act;
    logic [5:0]         idx;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] qx;
  } table_op_t;

  typedef struct {
    logic signed [31:0] y;
    logic [5:0]         seg;
    status_t            st;
  } interp_ans_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write_en = 1'b0;
  logic [PTS_W-1:0]   cfg_write_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               action = ACT_WRITE;
  logic [5:0]         entry_index = '0;
  logic signed [31:0] entry_x = '0;
  logic signed [31:0] entry_y = '0;
  logic signed [31:0] query_x = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] result_y;
  logic [5:0]         segment;
  logic [1:0]         status;

  table_op_t   pending_ops[$];
  interp_ans_t expected_answers[$];
  table_op_t   driven_op;
  interp_ans_t want;

  logic signed [31:0] bp_x [TABLE_DEPTH];
  logic signed [31:0] bp_y [TABLE_DEPTH];
  int unsigned        pts_cfg = PTS_RESET;

  logic signed [31:0] plan_x [TABLE_DEPTH];
  bit                 plan_written [TABLE_DEPTH];
  int unsigned        plan_pts = PTS_RESET;

  bit no_gaps = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int fail_count = 0;
  int checked_count = 0;
  int n_writes = 0;
  int n_lookups = 0;
  int n_few = 0;
  int n_flat = 0;
  int n_sat = 0;

  table_bisect_linear_interp_core u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .entry_index    (entry_index),
    .entry_x        (entry_x),
    .entry_y        (entry_y),
    .query_x        (query_x),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_y       (result_y),
    .segment        (segment),
    .status         (status)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic bit take_gap();
    return !no_gaps && ($urandom_range(99) < 13);
  endfunction

  // Applies one transaction to the predicted table and returns its answer.
  function automatic interp_ans_t predict_lookup(table_op_t op);
    interp_ans_t a;
    int unsigned n, lo, hi, mid;
    longint      q, x0, y0, x1, y1, dx, dy, dq, total;
    logic [63:0] prod, quo;
    bit          asc, neg;
    a.y   = '0;
    a.seg = '0;
    a.st  = ST_OK;
    if (op.act == ACT_WRITE) begin
      bp_x[op.idx] = op.ex;
      bp_y[op.idx] = op.ey;
      n_writes++;
      return a;
    end
    n_lookups++;
    n = (pts_cfg > TABLE_DEPTH) ? TABLE_DEPTH : pts_cfg;
    if (n < 2) begin
      a.st = ST_FEW_POINTS;
      n_few++;
      return a;
    end
    q   = longint'(op.qx);
    asc = bp_x[n-1] >= bp_x[0];
    lo  = 0;
    hi  = n - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if ((q >= longint'(bp_x[mid])) == asc) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    a.seg = lo[5:0];
    x0 = bp_x[lo];
    y0 = bp_y[lo];
    x1 = bp_x[lo+1];
    y1 = bp_y[lo+1];
    dx = x1 - x0;
    if (dx == 0) begin
      a.y  = y0[31:0];
      a.st = ST_ZERO_WIDTH;
      n_flat++;
      return a;
    end
    dy   = y1 - y0;
    dq   = q - x0;
    prod = magnitude(dy) * magnitude(dq);
    quo  = prod / magnitude(dx);
    if (quo > 64'h2_0000_0000) begin
      quo = 64'h2_0000_0000;
    end
    neg   = ((dy < 0) != (dq < 0)) != (dx < 0);
    total = neg ? y0 - longint'(quo) : y0 + longint'(quo);
    if (total > Y_MAX || total < Y_MIN) begin
      n_sat++;
    end
    if (total > Y_MAX) begin
      total = Y_MAX;
    end
    if (total < Y_MIN) begin
      total = Y_MIN;
    end
    a.y = total[31:0];
    return a;
  endfunction

  task automatic push_write(int idx, logic signed [31:0] x, logic signed [31:0] y);
    table_op_t op;
    op.act = ACT_WRITE;
    op.idx = idx[5:0];
    op.ex  = x;
    op.ey  = y;
    op.qx  = $urandom;
    pending_ops.push_back(op);
    plan_x[idx[5:0]]       = x;
    plan_written[idx[5:0]] = 1'b1;
  endtask

  task automatic push_query(logic signed [31:0] q);
    table_op_t op;
    op.act = ACT_QUERY;
    op.idx = $urandom_range(63);
    op.ex  = $urandom;
    op.ey  = $urandom;
    op.qx  = q;
    pending_ops.push_back(op);
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || in_valid || expected_answers.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic set_points(int v);
    drain();
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= PTS_W'(v);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    pts_cfg  = v;
    plan_pts = v;
    @(negedge clk);
  endtask

  // Driver: offers queued transactions and predicts each one as it is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_answers.push_back(predict_lookup(driven_op));
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 && !take_gap()) begin
          driven_op = pending_ops.pop_front();
          in_valid    <= 1'b1;
          action      <= driven_op.act;
          entry_index <= driven_op.idx;
          entry_x     <= driven_op.ex;
          entry_y     <= driven_op.ey;
          query_x     <= driven_op.qx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results in order and paces out_ready.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected result: result_y %0d segment %0d status %0d",
                 result_y, segment, status);
          fail_count++;
        end else begin
          want = expected_answers.pop_front();
          checked_count++;
          if (result_y !== want.y) begin
            $error("result_y: expected %0d, actual %0d", want.y, result_y);
            fail_count++;
          end
          if (segment !== want.seg) begin
            $error("segment: expected %0d, actual %0d", want.seg, segment);
            fail_count++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, actual %0d", want.st, status);
            fail_count++;
          end
        end
      end
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !take_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int           points_plan [PHASES];
    int           p, k, m, nq, reps, sel;
    bit           have_table;
    table_shape_t shape;
    longint       cap, stride, room, base, x, prev_x, y, q, lo_x, hi_x, span;

    points_plan = '{64, 127, 3, 2, 65, 100, 17, 40, 9, 64, 33, 5};
    points_plan[7]  = $urandom_range(127, 2);
    points_plan[10] = $urandom_range(64, 2);
    prev_x = 0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Full-scale segment in both directions through the 32-bit extremes.
    push_write(0, 32'h8000_0000, 32'h7FFF_FFFF);
    push_write(1, 32'h7FFF_FFFF, 32'h8000_0000);
    push_query(32'h8000_0000);
    push_query(32'h7FFF_FFFF);
    push_query(32'h0000_0000);
    push_query(32'hFFFF_FFFF);
    // A steep segment drives extrapolation into both saturation limits.
    push_write(0, 32'h0000_0000, 32'h8000_0000);
    push_write(1, 32'h0001_0000, 32'h7FFF_FFFF);
    push_query(32'h7FFF_FFFF);
    push_query(32'h8000_0000);
    push_query(32'h0000_8000);
    // Descending table, inside and beyond its ends.
    push_write(0, 32'h0001_0000, 32'h0000_0000);
    push_write(1, 32'h0000_0000, 32'h0001_0000);
    push_query(32'h0000_8000);
    push_query(32'h0002_0000);
    // Two equal abscissas give a zero-width segment.
    push_write(1, 32'h0001_0000, 32'h1234_5678);
    push_query(32'h0001_0000);
    push_query(32'h8000_0000);
    push_write(63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_write(42, 32'h5555_5555, 32'hAAAA_AAAA);
    push_write(21, 32'hAAAA_AAAA, 32'h5555_5555);
    set_points(0);
    push_query($urandom);
    set_points(1);
    push_query($urandom);

    for (p = 0; p < PHASES; p++) begin
      no_gaps = (p == 4);
      set_points(points_plan[p]);
      nq = (plan_pts > TABLE_DEPTH) ? TABLE_DEPTH : plan_pts;
      m  = (nq < 2) ? 2 : nq;
      have_table = 1'b1;
      for (k = 0; k < m; k++) begin
        if (!plan_written[k]) begin
          have_table = 1'b0;
        end
      end
      if (!have_table || $urandom_range(99) < 70) begin
        shape  = table_shape_t'($urandom_range(3));
        cap    = $urandom_range(1) ? 64'sd262144 : 64'sd4294967295 / m;
        stride = longint'($urandom_range(32'(cap), 1));
        room   = 64'sd4294967295 - m * stride;
        base   = -64'sd2147483648 + longint'({$urandom, $urandom} % (room + 1));
        for (k = 0; k < m; k++) begin
          x = base + k * stride + longint'($urandom % (stride / 2 + 1));
          if (shape == SHAPE_DUP && k > 0 && $urandom_range(3) == 0) begin
            x = prev_x;
          end
          if (shape == SHAPE_SCRAMBLE) begin
            x = longint'($signed($urandom));
          end
          prev_x = x;
          if ($urandom_range(1) == 1) begin
            y = longint'($signed($urandom));
          end else begin
            y = longint'($urandom_range(1 << 20)) - (1 << 19);
          end
          push_write((shape == SHAPE_DESC) ? m - 1 - k : k, x[31:0], y[31:0]);
        end
      end
      reps = $urandom_range(85, 55);
      for (k = 0; k < reps; k++) begin
        if (p == 5 && k == reps / 2) begin
          drain();
        end
        sel = $urandom_range(99);
        if (sel < 8) begin
          push_write($urandom_range(63), $urandom, $urandom);
        end else begin
          sel = $urandom_range(99);
          if (nq < 2 || sel >= 85) begin
            q = longint'($signed($urandom));
          end else if (sel < 25) begin
            q = longint'(plan_x[$urandom_range(nq - 1)]) + longint'($urandom_range(2)) - 1;
          end else if (sel < 75) begin
            lo_x = (plan_x[0] < plan_x[nq-1]) ? plan_x[0] : plan_x[nq-1];
            hi_x = (plan_x[0] < plan_x[nq-1]) ? plan_x[nq-1] : plan_x[0];
            span = hi_x - lo_x;
            if ($urandom_range(2) == 0) begin
              lo_x = lo_x - span / 4 - 1;
              hi_x = hi_x + span / 4 + 1;
              span = hi_x - lo_x;
            end
            q = lo_x + longint'({$urandom, $urandom} % (span + 1));
          end else begin
            case ($urandom_range(2))
              0: begin
                q = Y_MIN;
              end
              1: begin
                q = Y_MAX;
              end
              default: begin
                q = 0;
              end
            endcase
          end
          push_query(q[31:0]);
        end
      end
      if (p == 2) begin
        hold_request = 1'b1;
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results from %0d table writes and %0d lookups over %0d table sizes.",
             checked_count, n_writes, n_lookups, PHASES + 3);
    $display("Lookups with too few points: %0d, zero-width segments: %0d, saturated: %0d.",
             n_few, n_flat, n_sat);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
